### src/deo_pkg.sv
// Shared types, constants and register codes for the depth edge outliner.
`timescale 1ns / 1ps

package deo_pkg;

    localparam int MAX_LINE_WIDTH = 4096;
    localparam int COL_BITS       = $clog2(MAX_LINE_WIDTH);
    localparam int WIDTH_BITS     = 13;
    localparam int RANGE_BITS     = 24;
    localparam int THRESH_BITS    = 24;
    localparam int CHAN_BITS      = 8;
    localparam int CFG_IDX_BITS   = 4;
    localparam int CFG_DATA_BITS  = 24;
    localparam int S_TDATA_BITS   = 48;
    localparam int M_TDATA_BITS   = 24;

    localparam logic [CFG_IDX_BITS-1:0] REG_LINE_WIDTH     = 4'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_EDGE_THRESHOLD = 4'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_OUTLINE_GRAY   = 4'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_OUTLINE_ENABLE = 4'd3;

    localparam logic [WIDTH_BITS-1:0]  LINE_WIDTH_RST = 13'd1024;
    localparam logic [THRESH_BITS-1:0] THRESHOLD_RST  = 24'd2000;
    localparam logic [CHAN_BITS-1:0]   GRAY_RST       = 8'd38;
    localparam logic [WIDTH_BITS-1:0]  WIDTH_MAX      = WIDTH_BITS'(MAX_LINE_WIDTH);

    typedef struct packed {
        logic [COL_BITS-1:0] col;
        logic                first_row;
    } pos_t;

    typedef struct packed {
        logic [CHAN_BITS-1:0] blue;
        logic [CHAN_BITS-1:0] green;
        logic [CHAN_BITS-1:0] red;
    } rgb_t;

endpackage

### src/depth_edge_outliner_top.sv
// Top level of the depth edge outliner: config registers, pipeline and output register.
//
//  channel  | direction | handshake             | payload
//  s_       | in        | s_tvalid / s_tready   | s_tdata range,r,g,b; s_tuser frame_start
//  m_       | out       | m_tvalid / m_tready   | m_tdata r,g,b; m_tuser is_edge
//  cfg_     | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
//  One pixel per cycle sustained while m_tready is high; a pixel passes through the stage-1
//  registers and then the output register. The first stage reads the row above from the line
//  store and writes the new range; the second stage compares and lands the result in the output register.
//  Reset clears the position (column 0, first row) and the valid flags; the line
//  store is not cleared.
//  Backpressure on m_ holds both stages; s_tready drops only when both are full.
`timescale 1ns / 1ps

module depth_edge_outliner_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [23:0] pixel_range, [31:24] red_in, [39:32] green_in, [47:40] blue_in
    input  logic [deo_pkg::S_TDATA_BITS-1:0]    s_tdata,
    // [0] frame_start
    input  logic [0:0]                          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [7:0] red_out, [15:8] green_out, [23:16] blue_out
    output logic [deo_pkg::M_TDATA_BITS-1:0]    m_tdata,
    // [0] is_edge
    output logic [0:0]                          m_tuser,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [deo_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [deo_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

    logic [deo_pkg::WIDTH_BITS-1:0]  line_width_reg;
    logic [deo_pkg::THRESH_BITS-1:0] threshold_reg;
    logic [deo_pkg::CHAN_BITS-1:0]   gray_reg;
    logic                            enable_reg;

    logic                            s1_valid_reg;
    logic [deo_pkg::RANGE_BITS-1:0]  s1_range_reg;
    deo_pkg::rgb_t                   s1_rgb_reg;
    logic                            s1_first_reg;
    logic [deo_pkg::RANGE_BITS-1:0]  above;

    logic                            m_valid_reg;
    deo_pkg::rgb_t                   m_rgb_reg;
    logic                            m_edge_reg;

    logic                            out_free;
    logic                            s1_advance;
    logic                            accept;
    deo_pkg::pos_t                   pos;
    logic [deo_pkg::RANGE_BITS-1:0]  here;
    deo_pkg::rgb_t                   rgb_in;
    deo_pkg::rgb_t                   rgb_res;
    logic                            edge_res;

    assign cfg_ready  = 1'b1;
    assign out_free   = !m_valid_reg || m_tready;
    assign s1_advance = s1_valid_reg && out_free;
    assign s_tready   = !s1_valid_reg || out_free;
    assign accept     = s_tvalid && s_tready;

    assign here         = s_tdata[deo_pkg::RANGE_BITS-1:0];
    assign rgb_in.red   = s_tdata[31:24];
    assign rgb_in.green = s_tdata[39:32];
    assign rgb_in.blue  = s_tdata[47:40];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_width_reg <= deo_pkg::LINE_WIDTH_RST;
            threshold_reg  <= deo_pkg::THRESHOLD_RST;
            gray_reg       <= deo_pkg::GRAY_RST;
            enable_reg     <= 1'b1;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                deo_pkg::REG_LINE_WIDTH: begin
                    line_width_reg <= cfg_data[deo_pkg::WIDTH_BITS-1:0];
                end
                deo_pkg::REG_EDGE_THRESHOLD: begin
                    threshold_reg <= cfg_data[deo_pkg::THRESH_BITS-1:0];
                end
                deo_pkg::REG_OUTLINE_GRAY: begin
                    gray_reg <= cfg_data[deo_pkg::CHAN_BITS-1:0];
                end
                deo_pkg::REG_OUTLINE_ENABLE: begin
                    enable_reg <= cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    deo_position u_position (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (accept),
        .frame_start (s_tuser[0]),
        .line_width  (line_width_reg),
        .pos         (pos)
    );

    deo_line_store u_line_store (
        .aclk    (aclk),
        .en      (accept),
        .addr    (pos.col),
        .wr_data (here),
        .rd_data (above)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (accept) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_advance) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_range_reg <= here;
            s1_rgb_reg   <= rgb_in;
            s1_first_reg <= pos.first_row;
        end
    end

    deo_edge_unit u_edge_unit (
        .here      (s1_range_reg),
        .above     (above),
        .first_row (s1_first_reg),
        .threshold (threshold_reg),
        .enable    (enable_reg),
        .gray      (gray_reg),
        .rgb_in    (s1_rgb_reg),
        .rgb_out   (rgb_res),
        .is_edge   (edge_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_advance) begin
            m_rgb_reg  <= rgb_res;
            m_edge_reg <= edge_res;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = {m_rgb_reg.blue, m_rgb_reg.green, m_rgb_reg.red};
    assign m_tuser[0] = m_edge_reg;

endmodule

### src/deo_position.sv
// Column and first-row tracker for the incoming pixel stream.
`timescale 1ns / 1ps

module deo_position (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             advance,
    input  logic                             frame_start,
    input  logic [deo_pkg::WIDTH_BITS-1:0]   line_width,
    output deo_pkg::pos_t                    pos
);

    logic [deo_pkg::COL_BITS-1:0]   column_reg, column_next;
    logic                           first_reg, first_next;
    logic [deo_pkg::WIDTH_BITS-1:0] width_use;
    logic [deo_pkg::COL_BITS-1:0]   col_start;
    logic                           first_start;
    logic [deo_pkg::WIDTH_BITS-1:0] col_inc;

    always_comb begin
        priority if (line_width == '0) begin
            width_use = deo_pkg::WIDTH_BITS'(1);
        end else if (line_width > deo_pkg::WIDTH_MAX) begin
            width_use = deo_pkg::WIDTH_MAX;
        end else begin
            width_use = line_width;
        end
    end

    always_comb begin
        col_start   = frame_start ? '0 : column_reg;
        first_start = frame_start ? 1'b1 : first_reg;
        // width lowered mid row: treat as start of the next row
        if ({1'b0, col_start} >= width_use) begin
            pos.col       = '0;
            pos.first_row = 1'b0;
        end else begin
            pos.col       = col_start;
            pos.first_row = first_start;
        end
        col_inc = {1'b0, pos.col} + deo_pkg::WIDTH_BITS'(1);
        if (col_inc >= width_use) begin
            column_next = '0;
            first_next  = 1'b0;
        end else begin
            column_next = col_inc[deo_pkg::COL_BITS-1:0];
            first_next  = pos.first_row;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_reg <= '0;
            first_reg  <= 1'b1;
        end else if (advance) begin
            column_reg <= column_next;
            first_reg  <= first_next;
        end
    end

endmodule

### src/deo_line_store.sv
// Line store: ranges of the previous row, one write and one registered read.
`timescale 1ns / 1ps

module deo_line_store (
    input  logic                             aclk,
    input  logic                             en,
    input  logic [deo_pkg::COL_BITS-1:0]     addr,
    input  logic [deo_pkg::RANGE_BITS-1:0]   wr_data,
    output logic [deo_pkg::RANGE_BITS-1:0]   rd_data
);

    logic [deo_pkg::RANGE_BITS-1:0] mem [deo_pkg::MAX_LINE_WIDTH];

    // read returns the old entry, i.e. the row above
    always_ff @(posedge aclk) begin
        if (en) begin
            rd_data   <= mem[addr];
            mem[addr] <= wr_data;
        end
    end

endmodule

### src/deo_edge_unit.sv
// Edge decision and color substitution for one pixel.
`timescale 1ns / 1ps

module deo_edge_unit (
    input  logic [deo_pkg::RANGE_BITS-1:0]  here,
    input  logic [deo_pkg::RANGE_BITS-1:0]  above,
    input  logic                            first_row,
    input  logic [deo_pkg::THRESH_BITS-1:0] threshold,
    input  logic                            enable,
    input  logic [deo_pkg::CHAN_BITS-1:0]   gray,
    input  deo_pkg::rgb_t                   rgb_in,
    output deo_pkg::rgb_t                   rgb_out,
    output logic                            is_edge
);

    logic [deo_pkg::RANGE_BITS-1:0] diff;

    always_comb begin
        diff    = (here >= above) ? (here - above) : (above - here);
        is_edge = !first_row && (here != '0) && enable
                  && ((above == '0) || (diff > threshold));
        if (is_edge) begin
            rgb_out.red   = gray;
            rgb_out.green = gray;
            rgb_out.blue  = gray;
        end else begin
            rgb_out = rgb_in;
        end
    end

endmodule

### src/deo_checker.sv
// Port-level checks for the depth edge outliner, bound to the top level.
`timescale 1ns / 1ps

module deo_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic [0:0]                          s_tuser,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [deo_pkg::M_TDATA_BITS-1:0]    m_tdata,
    input  logic [0:0]                          m_tuser
);

    // no output transfer pending right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled output changed");

    // an outlined pixel carries the same gray in all channels
    a_gray: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |->
            (m_tdata[7:0] == m_tdata[15:8]) && (m_tdata[15:8] == m_tdata[23:16]))
        else $error("edge pixel with unequal channels");

    // first pixel of a frame is never outlined and reaches the output unless m_tready stalls it
    a_frame_first: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser[0]) ##1 m_tready |=> m_tvalid && !m_tuser[0])
        else $error("frame start pixel outlined or late");

endmodule

bind depth_edge_outliner_top deo_checker u_deo_checker (.*);
